// File: design/sha256_stream_hasher_top_macros.svh
// assertion macros for the hasher checker
// no dependencies
`ifndef SHA256_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_STREAM_HASHER_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define SHA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication with the consequent checked at the next clock edge outside reset
`define SHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: design/sha_pkg.sv
// package for the sha-256 stream hasher: constants, types and round functions
// no dependencies
package sha_pkg;
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // first padding byte after the message
  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef logic [31:0] word_t;

  // controller commands to the datapath
  typedef struct packed {
    logic load_byte;   // write absorb byte at fill level
    logic pad_byte;    // write padding byte (0x80, zero or length)
    logic pad_first;   // padding byte is the 0x80 marker
    logic pad_len;     // this block carries the length in bytes 56..63
    logic start_comp;  // load working regs from hash state
    logic round;       // one compression round
    logic fold;        // add working regs into hash state
    logic restart;     // back to initial values
  } ctl_cmd_t;

  typedef struct packed {
    logic       buf_full;   // fill level reached 63 before this byte
    logic [6:0] fill;
    logic [5:0] round_idx;
  } dp_status_t;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    word_t h [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                     32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

  function automatic word_t rotr(input word_t v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction
endpackage

// File: design/sha_datapath.sv
// sha-256 datapath: block buffer, schedule, working registers, hash state
// depends on sha_pkg
module sha_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  sha_pkg::ctl_cmd_t cmd,
  input  logic [7:0]        byte_in,
  input  logic [2:0]        rd_idx,
  output logic [31:0]       hash_word,
  output sha_pkg::dp_status_t status
);
  import sha_pkg::*;

  // block buffer held as sixteen big-endian words
  logic [31:0] blk_mem [16];
  logic [31:0] w_r [16];
  word_t       hash_r [8];
  word_t       a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [63:0] bits_r, bits_nxt;
  logic [6:0]  fill_r, fill_nxt;
  logic [5:0]  t_r;
  logic [7:0]  pad_val;
  logic [7:0]  wr_val;
  word_t       w_cur, s0, s1, t1, t2, mw;

  // padding byte: 0x80 first, zeros, then length big-endian in bytes 56..63
  always_comb begin
    pad_val = 8'h00;
    if (cmd.pad_first) pad_val = PAD_MARK;
    else if (cmd.pad_len && fill_r[5:0] >= 6'd56) pad_val = bits_r[8*(63-fill_r[5:0]) +: 8];
  end
  assign wr_val = cmd.load_byte ? byte_in : pad_val;

  // message word from the buffer for the first sixteen rounds
  assign mw = blk_mem[t_r[3:0]];

  always_comb begin
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_cur = (t_r < 6'd16) ? mw : (s1 + w_r[9] + s0 + w_r[0]);
    t1 = h_r + (rotr(e_r, 6) ^ rotr(e_r, 11) ^ rotr(e_r, 25)) + ((e_r & f_r) ^ (~e_r & g_r))
         + round_k(t_r) + w_cur;
    t2 = (rotr(a_r, 2) ^ rotr(a_r, 13) ^ rotr(a_r, 22)) + ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));
  end

  // fill level and bit counter
  always_comb begin
    fill_nxt = fill_r;
    bits_nxt = bits_r;
    if (cmd.load_byte) begin
      bits_nxt = bits_r + 64'd8;
      fill_nxt = (fill_r[5:0] == 6'd63) ? 7'd0 : fill_r + 7'd1;
    end else if (cmd.pad_byte) begin
      fill_nxt = (fill_r[5:0] == 6'd63) ? 7'd0 : fill_r + 7'd1;
    end
    if (cmd.restart) begin
      fill_nxt = 7'd0;
      bits_nxt = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 7'd0;
      bits_r <= 64'd0;
      t_r    <= 6'd0;
      for (int i = 0; i < 8; i++) hash_r[i] <= init_h(3'(i));
    end else begin
      fill_r <= fill_nxt;
      bits_r <= bits_nxt;
      if (cmd.start_comp) t_r <= 6'd0;
      else if (cmd.round) t_r <= t_r + 6'd1;
      if (cmd.fold) begin
        hash_r[0] <= hash_r[0] + a_r; hash_r[1] <= hash_r[1] + b_r;
        hash_r[2] <= hash_r[2] + c_r; hash_r[3] <= hash_r[3] + d_r;
        hash_r[4] <= hash_r[4] + e_r; hash_r[5] <= hash_r[5] + f_r;
        hash_r[6] <= hash_r[6] + g_r; hash_r[7] <= hash_r[7] + h_r;
      end else if (cmd.restart) begin
        for (int i = 0; i < 8; i++) hash_r[i] <= init_h(3'(i));
      end
    end
  end

  // block buffer writes, one byte lane at a time
  always_ff @(posedge clk) begin
    if (cmd.load_byte || cmd.pad_byte)
      blk_mem[fill_r[5:2]][8*(3-fill_r[1:0]) +: 8] <= wr_val;
  end

  // working registers and rolling schedule window
  always_ff @(posedge clk) begin
    if (cmd.start_comp) begin
      a_r <= hash_r[0]; b_r <= hash_r[1]; c_r <= hash_r[2]; d_r <= hash_r[3];
      e_r <= hash_r[4]; f_r <= hash_r[5]; g_r <= hash_r[6]; h_r <= hash_r[7];
    end else if (cmd.round) begin
      h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
      d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_cur;
    end
  end

  assign hash_word = hash_r[rd_idx];
  assign status.buf_full = (fill_r[5:0] == 6'd63);
  assign status.fill = fill_r;
  assign status.round_idx = t_r;
endmodule

// File: design/sha_ctrl.sv
// sha-256 controller: handshake, padding sequence, rounds, digest output
// depends on sha_pkg
module sha_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_op,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [2:0]          rd_idx,
  input  sha_pkg::dp_status_t status,
  output sha_pkg::ctl_cmd_t   cmd
);
  import sha_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_START = 6'b000100,
    S_ROUND = 6'b001000,
    S_FOLD  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic       fin_r, fin_nxt;      // finishing a message
  logic       first_r, first_nxt;  // 0x80 byte not yet written
  logic       last_r, last_nxt;    // block being padded is the length block
  logic [2:0] idx_r, idx_nxt;
  logic       acc;

  assign acc = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign rd_idx = idx_r;

  always_comb begin
    state_nxt = state_r;
    fin_nxt = fin_r; first_nxt = first_r; last_nxt = last_r; idx_nxt = idx_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_op == OP_ABSORB) begin
            cmd.load_byte = 1'b1;
            if (status.buf_full) begin
              state_nxt = S_START; fin_nxt = 1'b0; last_nxt = 1'b0;
            end
          end else begin
            state_nxt = S_PAD; fin_nxt = 1'b1; first_nxt = 1'b1;
          end
        end
      end
      // one pad byte a cycle: 0x80, zeros, then the length
      S_PAD: begin
        cmd.pad_byte = 1'b1;
        first_nxt = 1'b0;
        if (first_r) begin
          // marker past byte 55 pushes the length into an extra block
          cmd.pad_first = 1'b1;
          last_nxt = (status.fill[5:0] < 6'd56);
        end else begin
          cmd.pad_len = last_r;
        end
        if (status.buf_full) state_nxt = S_START;
      end
      S_START: begin
        cmd.start_comp = 1'b1;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (status.round_idx == 6'd63) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (!fin_r) state_nxt = S_IDLE;
        else if (last_r) begin
          state_nxt = S_OUT; idx_nxt = 3'd0;
        end else begin
          state_nxt = S_PAD; last_nxt = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.restart = 1'b1; state_nxt = S_IDLE; fin_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; fin_r <= 1'b0; first_r <= 1'b0; last_r <= 1'b0; idx_r <= 3'd0;
    end else begin
      state_r <= state_nxt; fin_r <= fin_nxt; first_r <= first_nxt;
      last_r <= last_nxt; idx_r <= idx_nxt;
    end
  end
endmodule

// File: design/sha256_stream_hasher_top.sv
// sha-256 stream hasher, top level
// joins sha_ctrl and sha_datapath; depends on sha_pkg
//
// usage: each input word is an absorb (in_op 0, byte in in_data_byte) or a
// finish (in_op 1). absorbs are accepted while the 64-byte buffer has
// room; the 64th byte starts a compression (load, 64 rounds, fold)
// during which in_stall is high. a finish writes padding one byte a
// cycle up to the end of the block, compresses, and with 56 or more bytes
// pending pads and compresses a second block. the digest then leaves
// as eight out words, H0 first, word_index 0..7, last_word on the
// eighth; a stall on out_stall holds the word shown. input stays
// stalled until the eighth word is taken, and the hash state then
// returns to the initial values. reset (rst_n low, synchronous)
// empties the buffer, clears the bit counter and loads the initial values.
module sha256_stream_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic [2:0] rd_idx;

  sha_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .out_stall, .out_valid,
    .rd_idx, .status, .cmd
  );

  sha_datapath u_dp (
    .clk, .rst_n, .cmd, .byte_in(in_data_byte), .rd_idx,
    .hash_word(out_digest_word), .status
  );

  assign out_word_index = rd_idx;
  assign out_last_word = (rd_idx == 3'd7);
endmodule

// File: design/sha_checker.sv
// port-level checker for the sha-256 stream hasher, with its bind
// depends on sha256_stream_hasher_top_macros.svh
`include "sha256_stream_hasher_top_macros.svh"
module sha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);
  // no new input while a digest is being shown
  `SHA_ASSERT_IMP(a_out_blocks_in, out_valid, in_stall)
  // last flag only on the eighth word
  `SHA_ASSERT_IMP(a_last_idx, out_valid, out_last_word == (out_word_index == 3'd7))
  // words advance by one when taken
  `SHA_ASSERT_NEXT(a_idx_step, out_valid && !out_stall && !out_last_word,
                   out_valid && out_word_index == $past(out_word_index) + 3'd1)
  // stalled word holds its place
  `SHA_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_word_index))
endmodule

bind sha256_stream_hasher_top sha_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_word_index, .out_last_word
);

// File: dv/tb_sha256_stream_hasher_top.sv
// testbench for the sha-256 stream hasher: directed and random byte streams
// checked word by word against a built-in sha-256 model; depends on sha_pkg
`timescale 1ns / 100ps

module tb_sha256_stream_hasher_top;
  import sha_pkg::*;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_out_t;

  // sha-256 model and queue of expected digest words
  class digest_scoreboard;
    logic [31:0] hash_h [8];
    logic [63:0] msg_len_bits;
    logic [7:0]  block_buf [64];
    int unsigned fill;
    digest_out_t pending_words [$];
    int unsigned error_count;
    int unsigned digests_seen;

    function new();
      restart();
      error_count = 0;
      digests_seen = 0;
    endfunction

    function void restart();
      hash_h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      msg_len_bits = '0;
      fill = 0;
    endfunction

    function logic [31:0] ror(logic [31:0] v, int n);
      return (v >> n) | (v << (32 - n));
    endfunction

    function logic [31:0] k_const(int t);
      logic [31:0] kt [64];
      kt = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return kt[t];
    endfunction

    // one 64-round compression of the block buffer
    function void compress();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int t = 0; t < 16; t++)
        w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
      for (int t = 16; t < 64; t++) begin
        s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3];
      e = hash_h[4]; f = hash_h[5]; g = hash_h[6]; h = hash_h[7];
      for (int t = 0; t < 64; t++) begin
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
             + k_const(t) + w[t];
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
      hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
    endfunction

    // note an accepted input word
    function void note_input(logic op, logic [7:0] data);
      if (op == OP_ABSORB) begin
        block_buf[fill] = data;
        msg_len_bits += 64'd8;
        fill++;
        if (fill == 64) begin
          compress();
          fill = 0;
        end
      end else begin
        block_buf[fill] = 8'h80;
        fill++;
        // long tail spills into an extra block
        if (fill > 56) begin
          while (fill < 64) begin block_buf[fill] = 8'h00; fill++; end
          compress();
          fill = 0;
        end
        while (fill < 56) begin block_buf[fill] = 8'h00; fill++; end
        for (int i = 0; i < 8; i++) block_buf[63-i] = msg_len_bits[8*i +: 8];
        compress();
        for (int i = 0; i < 8; i++)
          pending_words.push_back('{hash_h[i], 3'(i), i == 7});
        restart();
      end
    endfunction

    // compare one output word with the oldest expected one
    function void check_output(digest_out_t got);
      digest_out_t exp_w;
      if (pending_words.size() == 0) begin
        $error("unexpected digest word %h", got.digest_word);
        error_count++;
        return;
      end
      exp_w = pending_words.pop_front();
      if (got.digest_word !== exp_w.digest_word) begin
        $error("digest_word expected %h actual %h", exp_w.digest_word, got.digest_word);
        error_count++;
      end
      if (got.word_index !== exp_w.word_index) begin
        $error("word_index expected %0d actual %0d", exp_w.word_index, got.word_index);
        error_count++;
      end
      if (got.last_word !== exp_w.last_word) begin
        $error("last_word expected %0d actual %0d", exp_w.last_word, got.last_word);
        error_count++;
      end
      if (got.last_word) digests_seen++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = OP_ABSORB;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  digest_scoreboard sb = new();
  int unsigned words_sent = 0;
  bit          hold_mode = 1'b0;
  bit          stall_rand = 1'b1;

  always #4 clk = ~clk;

  sha256_stream_hasher_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_op), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );

  // sample both channels at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_op, in_data_byte);
      if (out_valid && !out_stall)
        sb.check_output('{out_digest_word, out_word_index, out_last_word});
    end
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int unsigned phase;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_mode) out_stall <= 1'b1;
      else if (!stall_rand) out_stall <= 1'b0;
      else if ((phase / 40) % 3 == 2) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // offer one word and hold it until accepted; gap cycles before it
  task automatic send_word(logic op, logic [7:0] data, int unsigned gap);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_message(int unsigned len, bit walk);
    int unsigned burst;
    burst = 0;
    for (int unsigned i = 0; i < len; i++) begin
      if (burst == 0) burst = $urandom_range(1, 12);
      burst--;
      send_word(OP_ABSORB, walk ? 8'(i) : 8'($urandom),
                (burst == 0) ? $urandom_range(0, 5) : 0);
    end
    send_word(OP_FINISH, 8'($urandom), $urandom_range(0, 2));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty message, "abc", byte extremes, pad boundaries
    send_word(OP_FINISH, 8'hff, 0);
    send_word(OP_ABSORB, 8'h61, 0);
    send_word(OP_ABSORB, 8'h62, 0);
    send_word(OP_ABSORB, 8'h63, 0);
    send_word(OP_FINISH, 8'h00, 0);
    send_word(OP_ABSORB, 8'h00, 0);
    send_word(OP_ABSORB, 8'hff, 0);
    send_word(OP_ABSORB, 8'haa, 0);
    send_word(OP_ABSORB, 8'h55, 0);
    send_word(OP_FINISH, 8'h00, 0);
    // sender pauses until all digests are out
    drain();
    send_message(55, 1'b1);
    send_message(56, 1'b1);
    send_message(63, 1'b0);
    send_message(64, 1'b0);

    // receiver holds off while the sender keeps offering
    hold_mode = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_mode = 1'b0;
      end
      begin
        send_message(3, 1'b0);
        send_message(2, 1'b0);
      end
    join
    drain();

    // random messages, mostly short
    while (words_sent < 430) begin
      if ($urandom_range(0, 9) == 0) send_message($urandom_range(50, 70), 1'b0);
      else send_message($urandom_range(0, 12), 1'b0);
      if ($urandom_range(0, 7) == 0) stall_rand = ~stall_rand;
    end
    stall_rand = 1'b1;

    drain();
    repeat (250) @(posedge clk);
    $display("sent %0d words, %0d digests checked across empty, short, padding-edge",
             words_sent, sb.digests_seen);
    $display("and multi-block messages with random gaps and output stalls");
    if (sb.error_count == 0 && sb.pending_words.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // overall time limit
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
